// File: design/assert_macros.svh
// Assertion macros used by the checker module of the block.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define PRC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prc: same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define PRC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prc: next-cycle check failed");

`endif

// File: design/prc_pkg.sv
// Package of the proof rule checker: widths, formula and fact codes, rule numbers
// and the entry and write-port structs. Depends on nothing.
package prc_pkg;

  localparam int unsigned FormulaDepthDef = 4096;
  localparam int unsigned FactDepthDef    = 4096;
  localparam int unsigned IdxW            = 12;
  localparam int unsigned KindW           = 4;
  localparam int unsigned RuleW           = 4;
  localparam int unsigned NextFreeW       = 13;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [KindW-1:0] kind_t;
  typedef logic [RuleW-1:0] rule_t;

  // Formula kinds.
  localparam kind_t KEmpty = 4'd0;
  localparam kind_t KInit  = 4'd1;
  localparam kind_t KGoal  = 4'd2;
  localparam kind_t KUnion = 4'd4;
  localparam kind_t KInter = 4'd5;
  localparam kind_t KProg  = 4'd6;
  localparam kind_t KRegr  = 4'd7;
  localparam kind_t KNeg   = 4'd8;
  localparam kind_t KNone  = 4'd15;

  // Rule numbers.
  localparam rule_t RuleD1  = 4'd1;
  localparam rule_t RuleD2  = 4'd2;
  localparam rule_t RuleD3  = 4'd3;
  localparam rule_t RuleD4  = 4'd4;
  localparam rule_t RuleD5  = 4'd5;
  localparam rule_t RuleD6  = 4'd6;
  localparam rule_t RuleD7  = 4'd7;
  localparam rule_t RuleD8  = 4'd8;
  localparam rule_t RuleD9  = 4'd9;
  localparam rule_t RuleD10 = 4'd10;
  localparam rule_t RuleD11 = 4'd11;

  // Item modes.
  localparam logic ModeDefine = 1'b0;
  localparam logic ModeRule   = 1'b1;

  typedef enum logic [1:0] {
    FactNone,
    FactDead,
    FactSubset,
    FactUnsolv
  } fact_kind_e;

  typedef struct packed {
    kind_t kind;
    idx_t  left;
    idx_t  right;
  } fml_t;

  typedef struct packed {
    fact_kind_e kind;
    idx_t       first;
    idx_t       second;
  } fact_t;

  typedef struct packed {
    logic en;
    idx_t idx;
    fml_t data;
  } fml_wr_t;

  typedef struct packed {
    logic  en;
    idx_t  idx;
    fact_t data;
  } fact_wr_t;

endpackage

// File: design/prc_if.sv
// Handshake interfaces of the proof rule checker: the item channel and the result
// channel. Depends on prc_pkg.
interface prc_item_if;
  import prc_pkg::*;

  logic  valid;
  logic  ready;
  logic  mode;
  idx_t  formula_index;
  kind_t formula_kind;
  idx_t  left_child;
  idx_t  right_child;
  rule_t rule_number;
  idx_t  second_formula;
  idx_t  new_fact_index;
  idx_t  known_first;
  idx_t  known_second;
  idx_t  known_third;

  modport source (
    output valid, mode, formula_index, formula_kind, left_child, right_child,
           rule_number, second_formula, new_fact_index, known_first,
           known_second, known_third,
    input  ready
  );
  modport sink (
    input  valid, mode, formula_index, formula_kind, left_child, right_child,
           rule_number, second_formula, new_fact_index, known_first,
           known_second, known_third,
    output ready
  );
endinterface

interface prc_result_if;
  logic valid;
  logic ready;
  logic accepted;
  logic proven;

  modport source (output valid, accepted, proven, input ready);
  modport sink (input valid, accepted, proven, output ready);
endinterface

// File: design/prc_fml_mem.sv
// Formula table: one synchronous memory of kind and child indices, one read and
// one write port. Depends on prc_pkg.
module prc_fml_mem #(
  parameter int unsigned DEPTH = prc_pkg::FormulaDepthDef
) (
  input  logic            clk_i,
  input  prc_pkg::idx_t   rd_idx_i,
  output prc_pkg::fml_t   rd_data_o,
  input  prc_pkg::fml_wr_t wr_i
);
  import prc_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fml_t mem [DEPTH];
  fml_t rd_q;
  logic rd_ok_q;

  // Write port and registered read; an index beyond the table is flagged.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[AW'(wr_i.idx)] <= wr_i.data;
    end
    rd_q    <= mem[AW'(rd_idx_i)];
    rd_ok_q <= (32'(rd_idx_i) < 32'(DEPTH));
  end

  // An index beyond the table reads as a kind that matches nothing.
  assign rd_data_o = rd_ok_q ? rd_q : fml_t'{kind: KNone, left: '0, right: '0};

endmodule

// File: design/prc_fact_mem.sv
// Fact table: one synchronous memory of fact kind and operands, cleared by a
// sweep after reset. Depends on prc_pkg.
module prc_fact_mem #(
  parameter int unsigned DEPTH = prc_pkg::FactDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prc_pkg::idx_t     rd_idx_i,
  output prc_pkg::fact_t    rd_data_o,
  input  prc_pkg::fact_wr_t wr_i,
  output logic              busy_o
);
  import prc_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fact_t         mem [DEPTH];
  fact_t         rd_q;
  logic          rd_ok_q;
  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;

  // Clearing sweep: one entry a cycle from the first to the last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // Write port shared by the sweep and the sequencer; registered read.
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (wr_i.en) begin
      mem[AW'(wr_i.idx)] <= wr_i.data;
    end
    rd_q    <= mem[AW'(rd_idx_i)];
    rd_ok_q <= (32'(rd_idx_i) < 32'(DEPTH));
  end

  // An index beyond the table reads as no fact.
  assign rd_data_o = rd_ok_q ? rd_q : '0;
  assign busy_o    = clr_q;

endmodule

// File: design/prc_ctrl.sv
// Sequencer of the proof rule checker: runs the chain of table reads for a rule,
// evaluates it and writes back formulas and facts. Depends on prc_pkg, prc_if.
module prc_ctrl #(
  parameter int unsigned FORMULA_DEPTH = prc_pkg::FormulaDepthDef,
  parameter int unsigned FACT_DEPTH    = prc_pkg::FactDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  prc_item_if.sink            item_i,
  prc_result_if.source        result_o,
  output prc_pkg::idx_t       fml_rd_idx_o,
  input  prc_pkg::fml_t       fml_rd_i,
  output prc_pkg::fml_wr_t    fml_wr_o,
  output prc_pkg::idx_t       fact_rd_idx_o,
  input  prc_pkg::fact_t      fact_rd_i,
  output prc_pkg::fact_wr_t   fact_wr_o,
  input  logic                clear_busy_i
);
  import prc_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StS1, StS2, StS3, StS4, StS5, StS6, StS7, StEval, StFin
  } state_e;

  state_e state_q;
  logic   mode_q;
  idx_t   fi_q, lc_q, rc_q, f2_q, nk_q, k1_q, k2_q, k3_q;
  kind_t  kind_q;
  rule_t  rule_q;
  fml_t   f0_q, g1_q, gu_q, gc_q, g5_q, g6_q;
  fact_t  t1_q, t2_q, t3_q;
  logic   ok_q;
  logic [NextFreeW-1:0] next_free_q;
  logic   proven_q;
  logic   res_valid_q, res_acc_q, res_prv_q;

  logic   item_acc, fin_go, rule_ok, proves;
  idx_t   subj;
  kind_t  cc_op, nt_outer, nt_inner;
  logic   cc_ok, gcd_ok, is_ok, nt_ok;
  fact_t  new_fact;

  assign item_i.ready    = (state_q == StIdle) && !clear_busy_i;
  assign item_acc        = item_i.valid && item_i.ready;
  assign fin_go          = (state_q == StFin) && (!res_valid_q || result_o.ready);
  assign result_o.valid    = res_valid_q;
  assign result_o.accepted = res_acc_q;
  assign result_o.proven   = res_prv_q;

  // Read addresses for each step of the lookup chain.
  always_comb begin
    fml_rd_idx_o  = fi_q;
    fact_rd_idx_o = k1_q;
    case (state_q)
      StS2: begin
        fml_rd_idx_o  = fact_rd_i.first;
        fact_rd_idx_o = k2_q;
      end
      StS3: begin
        fml_rd_idx_o  = t1_q.second;
        fact_rd_idx_o = k3_q;
      end
      StS4: fml_rd_idx_o = fact_rd_i.first;
      StS5: begin
        if (rule_q == RuleD6 || rule_q == RuleD8) begin
          fml_rd_idx_o = fml_rd_i.right;
        end else if (rule_q == RuleD9) begin
          fml_rd_idx_o = t3_q.second;
        end else begin
          fml_rd_idx_o = f0_q.left;
        end
      end
      StS6: fml_rd_idx_o = f2_q;
      default: ;
    endcase
  end

  // Shared sub-checks over the captured lookups.
  always_comb begin
    subj     = (rule_q == RuleD7 || rule_q == RuleD8) ? f0_q.left : fi_q;
    cc_op    = (rule_q == RuleD6 || rule_q == RuleD7) ? KProg : KRegr;
    nt_outer = (rule_q == RuleD10) ? KProg : KRegr;
    nt_inner = (rule_q == RuleD10) ? KRegr : KProg;
    cc_ok  = (t1_q.kind == FactSubset) && (g1_q.kind == cc_op) && (g1_q.left == subj)
             && (gu_q.kind == KUnion) && (gu_q.left == subj)
             && (t2_q.kind == FactDead) && (t2_q.first == gu_q.right);
    gcd_ok = (t3_q.kind == FactDead) && (gc_q.kind == KInter) && (gc_q.left == fi_q)
             && (g5_q.kind == KGoal);
    is_ok  = (t3_q.kind == FactSubset) && (gc_q.kind == KInit);
    nt_ok  = (f0_q.kind == nt_outer) && (g5_q.kind == KNeg) && (g6_q.kind == KNeg)
             && (t1_q.kind == FactSubset) && (g1_q.kind == nt_inner)
             && (g1_q.left == g6_q.left) && (t1_q.second == g5_q.left);
  end

  // Rule decoder.
  always_comb begin
    rule_ok  = 1'b0;
    proves   = 1'b0;
    new_fact = '{kind: FactDead, first: fi_q, second: '0};
    unique case (rule_q) inside
      RuleD1: rule_ok = (f0_q.kind == KEmpty);
      RuleD2: rule_ok = (f0_q.kind == KUnion)
                        && (t1_q.kind == FactDead) && (t1_q.first == f0_q.left)
                        && (t2_q.kind == FactDead) && (t2_q.first == f0_q.right);
      RuleD3: rule_ok = (t1_q.kind == FactSubset) && (t1_q.first == fi_q)
                        && (t2_q.kind == FactDead) && (t2_q.first == t1_q.second);
      RuleD4, RuleD5: begin
        rule_ok  = (t1_q.kind == FactDead)
                   && (g1_q.kind == ((rule_q == RuleD4) ? KInit : KGoal));
        proves   = 1'b1;
        new_fact = '{kind: FactUnsolv, first: '0, second: '0};
      end
      RuleD6: rule_ok = cc_ok && gcd_ok;
      RuleD7: rule_ok = (f0_q.kind == KNeg) && cc_ok && is_ok
                        && (t3_q.second == f0_q.left);
      RuleD8: rule_ok = (f0_q.kind == KNeg) && cc_ok && gcd_ok;
      RuleD9: rule_ok = cc_ok && is_ok && (g5_q.kind == KNeg) && (g5_q.left == fi_q);
      RuleD10, RuleD11: begin
        rule_ok  = nt_ok;
        new_fact = '{kind: FactSubset, first: fi_q, second: f2_q};
      end
      default: rule_ok = 1'b0;
    endcase
  end

  // Write-back at the end of an item.
  always_comb begin
    fml_wr_o  = '{en: fin_go && (mode_q == ModeDefine) && ok_q, idx: fi_q,
                  data: '{kind: kind_q, left: lc_q, right: rc_q}};
    fact_wr_o = '{en: fin_go && (mode_q == ModeRule) && ok_q, idx: nk_q,
                  data: new_fact};
  end

  // State, captured lookups and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      next_free_q <= '0;
      proven_q    <= 1'b0;
      res_valid_q <= 1'b0;
      res_acc_q   <= 1'b0;
      res_prv_q   <= 1'b0;
      ok_q        <= 1'b0;
    end else begin
      if (res_valid_q && result_o.ready && !fin_go) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (item_acc) begin
            mode_q <= item_i.mode;
            fi_q   <= item_i.formula_index;
            kind_q <= item_i.formula_kind;
            lc_q   <= item_i.left_child;
            rc_q   <= item_i.right_child;
            rule_q <= item_i.rule_number;
            f2_q   <= item_i.second_formula;
            nk_q   <= item_i.new_fact_index;
            k1_q   <= item_i.known_first;
            k2_q   <= item_i.known_second;
            k3_q   <= item_i.known_third;
            if (item_i.mode == ModeDefine) begin
              ok_q    <= (32'(item_i.formula_index) < 32'(FORMULA_DEPTH));
              state_q <= StFin;
            end else begin
              state_q <= StS1;
            end
          end
        end
        StS1: state_q <= StS2;
        StS2: begin
          f0_q    <= fml_rd_i;
          t1_q    <= fact_rd_i;
          state_q <= StS3;
        end
        StS3: begin
          g1_q    <= fml_rd_i;
          t2_q    <= fact_rd_i;
          state_q <= StS4;
        end
        StS4: begin
          gu_q    <= fml_rd_i;
          t3_q    <= fact_rd_i;
          state_q <= StS5;
        end
        StS5: begin
          gc_q    <= fml_rd_i;
          state_q <= StS6;
        end
        StS6: begin
          g5_q    <= fml_rd_i;
          state_q <= StS7;
        end
        StS7: begin
          g6_q    <= fml_rd_i;
          state_q <= StEval;
        end
        StEval: begin
          ok_q    <= rule_ok && ({1'b0, nk_q} >= next_free_q)
                     && (32'(nk_q) < 32'(FACT_DEPTH));
          state_q <= StFin;
        end
        StFin: begin
          if (fin_go) begin
            res_valid_q <= 1'b1;
            res_acc_q   <= ok_q;
            res_prv_q   <= proven_q || ((mode_q == ModeRule) && ok_q && proves);
            if ((mode_q == ModeRule) && ok_q) begin
              next_free_q <= {1'b0, nk_q} + 1'b1;
              if (proves) begin
                proven_q <= 1'b1;
              end
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// File: design/proof_rule_checker_unit.sv
// A rule item steps through the states S1 to S7, Eval and Fin, a define item straight to
// Fin; the result is registered in Fin, which waits while a held result is not taken.
// A new item is accepted only in Idle, after that result; six formula-table reads share
// one registered read port, and the deepest dependent chain of reads is 3.
// Reset: asynchronous, active low; afterwards a sweep clears all FACT_DEPTH entries of the
// fact memory, during which no item is accepted.
module proof_rule_checker_unit #(
  parameter int unsigned FORMULA_DEPTH = prc_pkg::FormulaDepthDef,
  parameter int unsigned FACT_DEPTH    = prc_pkg::FactDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  prc_item_if.sink     item_i,
  prc_result_if.source result_o
);
  import prc_pkg::*;

  idx_t     fml_rd_idx, fact_rd_idx;
  fml_t     fml_rd;
  fact_t    fact_rd;
  fml_wr_t  fml_wr;
  fact_wr_t fact_wr;
  logic     clear_busy;

  // Formula table.
  prc_fml_mem #(.DEPTH(FORMULA_DEPTH)) u_fml_mem (
    .clk_i     (clk_i),
    .rd_idx_i  (fml_rd_idx),
    .rd_data_o (fml_rd),
    .wr_i      (fml_wr)
  );

  // Fact table with its clearing sweep.
  prc_fact_mem #(.DEPTH(FACT_DEPTH)) u_fact_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (fact_rd_idx),
    .rd_data_o (fact_rd),
    .wr_i      (fact_wr),
    .busy_o    (clear_busy)
  );

  // Sequencer.
  prc_ctrl #(
    .FORMULA_DEPTH (FORMULA_DEPTH),
    .FACT_DEPTH    (FACT_DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_i),
    .result_o      (result_o),
    .fml_rd_idx_o  (fml_rd_idx),
    .fml_rd_i      (fml_rd),
    .fml_wr_o      (fml_wr),
    .fact_rd_idx_o (fact_rd_idx),
    .fact_rd_i     (fact_rd),
    .fact_wr_o     (fact_wr),
    .clear_busy_i  (clear_busy)
  );

endmodule

// File: design/prc_checker.sv
// Port-level checker of the proof rule checker and its bind to the top level.
// Depends on assert_macros.svh and proof_rule_checker_unit.
`include "assert_macros.svh"

module prc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_proven_i
);

  // One transaction at a time: ready drops after an accepted item.
  `PRC_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  // Once proven, every later result reports it.
  `PRC_ASSERT_NEXT(a_proven_sticky, clk_i, rst_ni, out_proven_i, out_proven_i)
  // A stalled result stays offered.
  `PRC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  // The proven flag only appears together with a result.
  `PRC_ASSERT_IMPL(a_proven_with_result, clk_i, rst_ni, $rose(out_proven_i), out_valid_i)

endmodule

bind proof_rule_checker_unit prc_checker u_prc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_proven_i (result_o.proven)
);

// File: tb/sv/proof_rule_checker_unit_test.sv
// Self-checking testbench of proof_rule_checker_unit: formula definitions, rules D1 to D11,
// fact ordering and the proven flag, with random idling on both channels.
// Depends on prc_pkg, prc_item_if, prc_result_if and proof_rule_checker_unit.
module proof_rule_checker_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import prc_pkg::*;

  localparam int unsigned Depth = 4096;

  typedef struct {
    logic  mode;
    idx_t  fi;
    kind_t kind;
    idx_t  lc;
    idx_t  rc;
    rule_t rule;
    idx_t  f2;
    idx_t  nk;
    idx_t  k1;
    idx_t  k2;
    idx_t  k3;
  } step_t;

  typedef struct {
    logic accepted;
    logic proven;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  prc_item_if   item_bus ();
  prc_result_if result_bus ();

  proof_rule_checker_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_bus),
    .result_o(result_bus)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the formula and fact tables.
  kind_t      fml_kind_q [Depth];
  idx_t       fml_left_q [Depth];
  idx_t       fml_right_q[Depth];
  bit         fml_written[Depth];
  fact_kind_e fact_kind_q[Depth];
  idx_t       fact_a_q   [Depth];
  idx_t       fact_b_q   [Depth];
  int unsigned next_free;
  bit          proven_q;
  bit          undef_hit;

  verdict_t verdicts_due[$];
  idx_t     dead_facts[$];
  idx_t     known_fmls[$];
  int       errors;
  int       src_stall_max;
  int       snk_stall_max;

  // Table lookups; reading a formula never written marks the step as unusable.
  function automatic kind_t fk(idx_t i);
    if (!fml_written[i]) undef_hit = 1'b1;
    return fml_kind_q[i];
  endfunction

  function automatic idx_t fl(idx_t i);
    if (!fml_written[i]) undef_hit = 1'b1;
    return fml_left_q[i];
  endfunction

  function automatic idx_t fr(idx_t i);
    if (!fml_written[i]) undef_hit = 1'b1;
    return fml_right_q[i];
  endfunction

  function automatic bit fact_is_dead(idx_t k, idx_t f);
    return fact_kind_q[k] == FactDead && fact_a_q[k] == f;
  endfunction

  function automatic bit is_unary(idx_t f, kind_t kd, idx_t c);
    return fk(f) == kd && fl(f) == c;
  endfunction

  // Subset op(s) <= s | s2 together with s2 dead.
  function automatic bit closed_under(idx_t k1, idx_t k2, idx_t s, kind_t op);
    idx_t u;
    if (fact_kind_q[k1] != FactSubset) return 1'b0;
    if (!is_unary(fact_a_q[k1], op, s)) return 1'b0;
    u = fact_b_q[k1];
    if (fk(u) != KUnion || fl(u) != s) return 1'b0;
    return fact_is_dead(k2, fr(u));
  endfunction

  function automatic bit goal_part_dead(idx_t k, idx_t f);
    idx_t c;
    if (fact_kind_q[k] != FactDead) return 1'b0;
    c = fact_a_q[k];
    if (fk(c) != KInter || fl(c) != f) return 1'b0;
    return fk(fr(c)) == KGoal;
  endfunction

  function automatic bit init_within(idx_t k, output idx_t sup);
    sup = '0;
    if (fact_kind_q[k] != FactSubset) return 1'b0;
    if (fk(fact_a_q[k]) != KInit) return 1'b0;
    sup = fact_b_q[k];
    return 1'b1;
  endfunction

  function automatic bit neg_moves(idx_t f1, idx_t f2, idx_t k, kind_t outer, kind_t inner);
    idx_t a, si, spi;
    if (fk(f1) != outer) return 1'b0;
    a = fl(f1);
    if (fk(a) != KNeg || fk(f2) != KNeg) return 1'b0;
    si  = fl(f2);
    spi = fl(a);
    if (fact_kind_q[k] != FactSubset) return 1'b0;
    return is_unary(fact_a_q[k], inner, si) && fact_b_q[k] == spi;
  endfunction

  // Decides a rule step and the fact it would derive.
  function automatic void judge_rule(input step_t s, output bit ok, output fact_kind_e nkind,
                                     output idx_t na, output idx_t nb, output bit proves);
    idx_t sup;
    ok = 1'b0;
    nkind = FactDead;
    na = s.fi;
    nb = '0;
    proves = 1'b0;
    sup = '0;
    case (s.rule)
      RuleD1: ok = fk(s.fi) == KEmpty;
      RuleD2: ok = fk(s.fi) == KUnion && fact_is_dead(s.k1, fl(s.fi))
                   && fact_is_dead(s.k2, fr(s.fi));
      RuleD3: ok = fact_kind_q[s.k1] == FactSubset && fact_a_q[s.k1] == s.fi
                   && fact_is_dead(s.k2, fact_b_q[s.k1]);
      RuleD4, RuleD5: begin
        ok = fact_kind_q[s.k1] == FactDead
             && fk(fact_a_q[s.k1]) == (s.rule == RuleD4 ? KInit : KGoal);
        nkind = FactUnsolv;
        na = '0;
        proves = 1'b1;
      end
      RuleD6: ok = closed_under(s.k1, s.k2, s.fi, KProg) && goal_part_dead(s.k3, s.fi);
      RuleD7: ok = fk(s.fi) == KNeg && closed_under(s.k1, s.k2, fl(s.fi), KProg)
                   && init_within(s.k3, sup) && sup == fl(s.fi);
      RuleD8: ok = fk(s.fi) == KNeg && closed_under(s.k1, s.k2, fl(s.fi), KRegr)
                   && goal_part_dead(s.k3, s.fi);
      RuleD9: ok = closed_under(s.k1, s.k2, s.fi, KRegr) && init_within(s.k3, sup)
                   && is_unary(sup, KNeg, s.fi);
      RuleD10, RuleD11: begin
        ok = s.rule == RuleD10 ? neg_moves(s.fi, s.f2, s.k1, KProg, KRegr)
                               : neg_moves(s.fi, s.f2, s.k1, KRegr, KProg);
        nkind = FactSubset;
        nb = s.f2;
      end
      default: ok = 1'b0;
    endcase
    if (ok && s.nk < next_free) ok = 1'b0;
  endfunction

  // Sends one step unless it would read an unwritten formula; updates the shadow tables.
  task automatic send_step(input step_t s, output bit sent, output bit acc);
    bit ok, proves;
    fact_kind_e nkind;
    idx_t na, nb;
    int gap;
    undef_hit = 1'b0;
    ok = 1'b1;
    proves = 1'b0;
    nkind = FactDead;
    na = '0;
    nb = '0;
    if (s.mode == ModeRule) judge_rule(s, ok, nkind, na, nb, proves);
    sent = !undef_hit;
    acc = sent && ok;
    if (!sent) return;
    gap = $urandom_range(0, src_stall_max);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_bus.valid          <= 1'b1;
    item_bus.mode           <= s.mode;
    item_bus.formula_index  <= s.fi;
    item_bus.formula_kind   <= s.kind;
    item_bus.left_child     <= s.lc;
    item_bus.right_child    <= s.rc;
    item_bus.rule_number    <= s.rule;
    item_bus.second_formula <= s.f2;
    item_bus.new_fact_index <= s.nk;
    item_bus.known_first    <= s.k1;
    item_bus.known_second   <= s.k2;
    item_bus.known_third    <= s.k3;
    do @(posedge clk_i); while (item_bus.ready !== 1'b1);
    if (s.mode == ModeDefine) begin
      fml_kind_q[s.fi]  = s.kind;
      fml_left_q[s.fi]  = s.lc;
      fml_right_q[s.fi] = s.rc;
      fml_written[s.fi] = 1'b1;
      known_fmls.insert(known_fmls.size(), s.fi);
    end else if (ok) begin
      fact_kind_q[s.nk] = nkind;
      fact_a_q[s.nk]    = na;
      fact_b_q[s.nk]    = nb;
      next_free         = s.nk + 1;
      if (proves) proven_q = 1'b1;
      if (nkind == FactDead) dead_facts.insert(dead_facts.size(), s.nk);
    end
    verdicts_due.insert(verdicts_due.size(), verdict_t'{accepted: ok, proven: proven_q});
  endtask

  task automatic define_fml(input idx_t f, input kind_t kd, input idx_t l, input idx_t r);
    step_t s;
    bit sent, acc;
    s = '{mode: ModeDefine, fi: f, kind: kd, lc: l, rc: r, rule: RuleD1, f2: '0,
          nk: '0, k1: '0, k2: '0, k3: '0};
    send_step(s, sent, acc);
  endtask

  task automatic apply_rule(input rule_t rn, input idx_t f, input idx_t g, input idx_t nk,
                            input idx_t a, input idx_t b, input idx_t c, output bit acc);
    step_t s;
    bit sent;
    s = '{mode: ModeRule, fi: f, kind: kind_t'($urandom), lc: idx_t'($urandom),
          rc: idx_t'($urandom), rule: rn, f2: g, nk: nk, k1: a, k2: b, k3: c};
    send_step(s, sent, acc);
  endtask

  function automatic idx_t next_slot();
    int unsigned v;
    v = next_free + $urandom_range(0, 3);
    return idx_t'(v > Depth - 2 ? Depth - 2 : v);
  endfunction

  task automatic wait_drained();
    item_bus.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // Result side: random stalls, each transaction compared with the oldest verdict.
  initial begin
    verdict_t want;
    int gap;
    result_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, snk_stall_max);
      if (gap > 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(result_bus.valid === 1'b1 && result_bus.ready === 1'b1));
      if (verdicts_due.size() == 0) begin
        $error("unexpected result transaction: accepted %0b proven %0b",
               result_bus.accepted, result_bus.proven);
        errors++;
      end else begin
        want = verdicts_due.pop_front();
        if (result_bus.accepted !== want.accepted) begin
          $error("accepted: expected %0b, got %0b", want.accepted, result_bus.accepted);
          errors++;
        end
        if (result_bus.proven !== want.proven) begin
          $error("proven: expected %0b, got %0b", want.proven, result_bus.proven);
          errors++;
        end
      end
    end
  end

  // Extremes of the define fields and the undefined kind codes 10 to 14.
  task automatic test_defines();
    define_fml(12'd0, KEmpty, 12'd0, 12'd0);
    define_fml(12'd4095, KNone, 12'd4095, 12'd4095);
    for (int k = 10; k <= 14; k++) define_fml(idx_t'(4000 + k), kind_t'(k), 12'd0, 12'd4095);
  endtask

  // Rule numbers outside D1 to D11, and missing premises.
  task automatic test_unknown_rules();
    bit acc;
    apply_rule(rule_t'(0), 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, acc);
    for (int r = 12; r <= 15; r++)
      apply_rule(rule_t'(r), 12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, acc);
    apply_rule(RuleD3, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd0, acc);
    apply_rule(RuleD4, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd0, 12'd0, acc);
  endtask

  // D1, D2 and D3, and a fact slot below the next free one.
  task automatic test_dead_rules();
    bit acc;
    apply_rule(RuleD1, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, acc);
    apply_rule(RuleD1, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, acc);
    apply_rule(RuleD1, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, acc);
    define_fml(12'd1, KEmpty, 12'd0, 12'd0);
    apply_rule(RuleD1, 12'd1, 12'd0, 12'd3, 12'd0, 12'd0, 12'd0, acc);
    define_fml(12'd2, KUnion, 12'd0, 12'd1);
    apply_rule(RuleD2, 12'd2, 12'd0, 12'd4, 12'd3, 12'd0, 12'd0, acc);
    apply_rule(RuleD2, 12'd2, 12'd0, 12'd4, 12'd0, 12'd3, 12'd0, acc);
    apply_rule(RuleD3, 12'd2, 12'd0, 12'd5, 12'd4, 12'd0, 12'd0, acc);
  endtask

  // D6 to D11 walk their lookup chains; without subset facts they must reject.
  task automatic test_chain_rules();
    bit acc;
    define_fml(12'd10, KNeg, 12'd0, 12'd0);
    define_fml(12'd11, KProg, 12'd10, 12'd0);
    define_fml(12'd12, KRegr, 12'd10, 12'd0);
    define_fml(12'd13, KInter, 12'd10, 12'd4095);
    for (int r = 6; r <= 11; r++)
      apply_rule(rule_t'(r), r[0] ? 12'd12 : 12'd11, 12'd10, 12'd6, 12'd4, 12'd0, 12'd3, acc);
    apply_rule(RuleD10, 12'd11, 12'd10, 12'd6, 12'd4, 12'd0, 12'd0, acc);
    apply_rule(RuleD11, 12'd12, 12'd10, 12'd6, 12'd4, 12'd0, 12'd0, acc);
  endtask

  // A dead set turned into the init or goal set proves unsolvability.
  task automatic test_proof(input bit via_goal);
    idx_t f, d;
    bit acc;
    f = idx_t'($urandom_range(0, 4095));
    define_fml(f, KEmpty, idx_t'($urandom), idx_t'($urandom));
    d = next_slot();
    apply_rule(RuleD1, f, '0, d, '0, '0, '0, acc);
    define_fml(f, via_goal ? KGoal : KInit, '0, '0);
    apply_rule(via_goal ? RuleD4 : RuleD5, '0, '0, next_slot(), d, '0, '0, acc);
    apply_rule(via_goal ? RuleD5 : RuleD4, '0, '0, next_slot(), d, '0, '0, acc);
  endtask

  // Mostly well-formed unions of dead sets, the rest random or broken steps.
  task automatic test_random_steps(input int target);
    int count;
    step_t s;
    bit sent, acc;
    idx_t a, b, u, fa, fb;
    count = 0;
    while (count < target) begin
      if ($urandom_range(0, 99) < 65) begin
        a = idx_t'($urandom);
        b = idx_t'($urandom);
        u = idx_t'($urandom);
        define_fml(a, KEmpty, idx_t'($urandom), idx_t'($urandom));
        fa = next_slot();
        apply_rule(RuleD1, a, idx_t'($urandom), fa, idx_t'($urandom), '0, '0, acc);
        define_fml(b, KEmpty, '0, '0);
        fb = next_slot();
        apply_rule(RuleD1, b, '0, fb, '0, '0, '0, acc);
        define_fml(u, KUnion, a, b);
        if ($urandom_range(0, 3) == 0)
          apply_rule(RuleD2, u, '0, next_slot(), fb, fa, idx_t'($urandom), acc);
        else apply_rule(RuleD2, u, '0, next_slot(), fa, fb, idx_t'($urandom), acc);
        count += 6;
      end else begin
        s.mode = 1'($urandom_range(0, 1));
        s.fi   = known_fmls.size() > 0 && $urandom_range(0, 1) ?
                 known_fmls[$urandom_range(0, known_fmls.size() - 1)] : idx_t'($urandom);
        s.kind = kind_t'($urandom);
        s.lc   = idx_t'($urandom);
        s.rc   = idx_t'($urandom);
        s.rule = rule_t'($urandom);
        s.f2   = idx_t'($urandom);
        s.nk   = $urandom_range(0, 1) ? next_slot() : idx_t'($urandom_range(0, 4094));
        s.k1   = dead_facts.size() > 0 ?
                 dead_facts[$urandom_range(0, dead_facts.size() - 1)] : idx_t'($urandom);
        s.k2   = idx_t'($urandom);
        s.k3   = idx_t'($urandom);
        send_step(s, sent, acc);
        if (sent) count++;
      end
    end
  endtask

  // The last fact slot is taken; nothing can follow it.
  task automatic test_last_fact_slot();
    bit acc;
    define_fml(12'd4095, KEmpty, 12'd4095, 12'd4095);
    apply_rule(RuleD1, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, acc);
    apply_rule(RuleD1, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, acc);
  endtask

  initial begin
    errors = 0;
    next_free = 0;
    proven_q = 1'b0;
    src_stall_max = 6;
    snk_stall_max = 6;
    for (int i = 0; i < Depth; i++) begin
      fml_written[i] = 1'b0;
      fact_kind_q[i] = FactNone;
    end
    item_bus.valid = 1'b0;
    item_bus.mode = ModeDefine;
    item_bus.formula_index = '0;
    item_bus.formula_kind = KEmpty;
    item_bus.left_child = '0;
    item_bus.right_child = '0;
    item_bus.rule_number = RuleD1;
    item_bus.second_formula = '0;
    item_bus.new_fact_index = '0;
    item_bus.known_first = '0;
    item_bus.known_second = '0;
    item_bus.known_third = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defines();
    test_unknown_rules();
    test_dead_rules();
    test_chain_rules();
    src_stall_max = 0;
    snk_stall_max = 0;
    test_random_steps(120);
    src_stall_max = 6;
    snk_stall_max = 6;
    test_random_steps(150);
    // Hold the sender back until every verdict is in.
    wait_drained();
    test_proof(1'($urandom_range(0, 1)));
    snk_stall_max = 0;
    test_random_steps(100);
    snk_stall_max = 6;
    src_stall_max = 0;
    test_random_steps(100);
    src_stall_max = 6;
    test_random_steps(50);
    test_last_fact_slot();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("proof_rule_checker_unit: match");
    else $display("proof_rule_checker_unit: mismatch");
    $finish;
  end

  // Run limit.
  initial begin
    #5ms;
    $display("proof_rule_checker_unit: mismatch");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/prc_pkg.sv
design/prc_if.sv
design/prc_fml_mem.sv
design/prc_fact_mem.sv
design/prc_ctrl.sv
design/proof_rule_checker_unit.sv
design/prc_checker.sv
tb/sv/proof_rule_checker_unit_test.sv
